FILE: sv/tls_pkg.sv
package tls_pkg;

	localparam int MAX_DETECTIONS = 64;
	localparam int FRAC_BITS      = 12;
	localparam int POS_W          = $clog2(MAX_DETECTIONS);
	localparam int CNT_W          = POS_W + 1;

	localparam logic [12:0] SC_ONE = 13'd4096;
	localparam logic [9:0]  SC_WA  = 10'd614;
	localparam logic [10:0] SC_WB  = 11'd1434;
	localparam logic [7:0]  SC_WP  = 8'd205;

	localparam logic [4:0] MUL_LAST  = 5'd5;
	localparam logic [4:0] DIV_LAST  = 5'd23;
	localparam logic [4:0] AREA_BITS = 5'd12;
	localparam logic [4:0] SQRT_LAST = 5'd11;

	typedef enum logic [2:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_CLASS_FIRST  = 3'd2,
		REG_CLASS_SECOND = 3'd3,
		REG_CLASS_THIRD  = 3'd4,
		REG_MAX_LOST     = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_SQRT,
		ST_SUM,
		ST_BEST,
		ST_FRAME
	} state_t;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [7:0]  class_first;
		logic [7:0]  class_second;
		logic [7:0]  class_third;
		logic [7:0]  max_lost;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       prep;
		logic       div;
		logic       sqrt;
		logic       sum;
		logic       best;
		logic       frame;
		logic [4:0] step;
	} cmd_t;

	typedef struct packed {
		logic eligible;
		logic last_in;
		logic last_q;
	} sts_t;

	function automatic logic [9:0] prio_weight(input logic [1:0] prio);
		logic [9:0] w;
		case (prio)
			2'd1:    w = {2'b0, SC_WP};
			2'd2:    w = {1'b0, SC_WP, 1'b0};
			2'd3:    w = {2'b0, SC_WP} + {1'b0, SC_WP, 1'b0};
			default: w = 10'd0;
		endcase
		return w;
	endfunction

endpackage

FILE: sv/tls_ctrl.sv
module tls_ctrl import tls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.eligible)
						state_d = ST_MUL;
					else if (sts.last_in)
						state_d = ST_FRAME;
				end
			end
			ST_MUL:   if (cnt_q == MUL_LAST) state_d = ST_PREP;
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == DIV_LAST) state_d = ST_SQRT;
			ST_SQRT:  if (cnt_q == SQRT_LAST) state_d = ST_SUM;
			ST_SUM:   state_d = ST_BEST;
			ST_BEST:  state_d = sts.last_q ? ST_FRAME : ST_IDLE;
			ST_FRAME: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.step    = cnt_q;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_MUL:   cmd.mul   = 1'b1;
			ST_PREP:  cmd.prep  = 1'b1;
			ST_DIV:   cmd.div   = 1'b1;
			ST_SQRT:  cmd.sqrt  = 1'b1;
			ST_SUM:   cmd.sum   = 1'b1;
			ST_BEST:  cmd.best  = 1'b1;
			ST_FRAME: cmd.frame = out_free;
			default:  cmd       = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (cmd.frame)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// A result is only loaded when the output register is free or drains now.
	a_frame_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frame |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending result");

	a_elig_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.eligible) |=> state_q == ST_MUL)
		else $error("eligible item did not start scoring");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= DIV_LAST)
		else $error("division step count overran");

endmodule

FILE: sv/tls_dp.sv
module tls_dp import tls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        detection_valid,
	input  logic [7:0]  object_class,
	input  logic [12:0] confidence,
	input  logic [11:0] box_left,
	input  logic [11:0] box_top,
	input  logic [12:0] box_width,
	input  logic [12:0] box_height,
	input  logic [15:0] track_tag,
	input  logic        last_in_frame,
	output logic        target_found,
	output logic [5:0]  target_index,
	output logic [13:0] target_score,
	output logic        lock_active,
	output logic [15:0] locked_track,
	output logic [7:0]  lost_count
);

	// Captured item
	logic [11:0] left_q, top_q;
	logic [12:0] bw_q, bh_q, conf_q;
	logic [15:0] track_q;
	logic [1:0]  prio_q;
	logic        match_q, last_q;
	logic [POS_W-1:0] pos_q;

	// Frame and lock state
	logic [CNT_W-1:0] count_q;
	logic             best_found_q;
	logic [13:0]      best_score_q;
	logic [POS_W-1:0] best_pos_q;
	logic [15:0]      best_track_q;
	logic [15:0]      active_q;
	logic             lock_q;
	logic [7:0]       lost_q;

	// Arithmetic registers
	logic [27:0] dx2_q, dy2_q;
	logic [25:0] fw2_q, fh2_q, bwbh_q, fa_q;
	logic [26:0] m2_q, crem_q;
	logic [25:0] fad_q, arem_q;
	logic        czero_q, afull_q;
	logic [23:0] cq_q, bit_q;
	logic [11:0] aq_q;
	logic [24:0] root_q;
	logic [13:0] score_q;

	logic [12:0] fw, fh;
	logic [1:0]  prio;
	logic [13:0] xsum, ysum;
	logic signed [14:0] dxs, dys;
	logic [13:0] adx, ady;
	logic [13:0] mul_a, mul_b;
	logic [27:0] mul_p;

	assign fw = (cfg.frame_width == 13'd0) ? 13'd1 : cfg.frame_width;
	assign fh = (cfg.frame_height == 13'd0) ? 13'd1 : cfg.frame_height;

	always_comb begin
		if (object_class == cfg.class_first)
			prio = 2'd3;
		else if (object_class == cfg.class_second)
			prio = 2'd2;
		else if (object_class == cfg.class_third)
			prio = 2'd1;
		else
			prio = 2'd0;
	end

	assign sts.eligible = detection_valid && (prio != 2'd0)
		&& (count_q < CNT_W'(MAX_DETECTIONS));
	assign sts.last_in  = last_in_frame;
	assign sts.last_q   = last_q;

	// Offsets from the frame center in half pixels.
	assign xsum = {1'b0, left_q, 1'b0} + {1'b0, bw_q};
	assign ysum = {1'b0, top_q, 1'b0} + {1'b0, bh_q};
	assign dxs  = $signed({1'b0, xsum}) - $signed({2'b0, fw});
	assign dys  = $signed({1'b0, ysum}) - $signed({2'b0, fh});
	assign adx  = dxs[14] ? 14'(-dxs) : dxs[13:0];
	assign ady  = dys[14] ? 14'(-dys) : dys[13:0];

	always_comb begin
		case (cmd.step)
			5'd0:    begin mul_a = adx;          mul_b = adx;          end
			5'd1:    begin mul_a = ady;          mul_b = ady;          end
			5'd2:    begin mul_a = {1'b0, fw};   mul_b = {1'b0, fw};   end
			5'd3:    begin mul_a = {1'b0, fh};   mul_b = {1'b0, fh};   end
			5'd4:    begin mul_a = {1'b0, bw_q}; mul_b = {1'b0, bh_q}; end
			default: begin mul_a = {1'b0, fw};   mul_b = {1'b0, fh};   end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Setup values for the two dividers
	logic [28:0] d2, a5;
	logic [26:0] m2s, m2;
	logic [25:0] fad;
	assign d2  = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign m2s = {1'b0, fw2_q} + {1'b0, fh2_q};
	assign m2  = (m2s < 27'd4) ? 27'd4 : m2s;
	assign fad = (fa_q < 26'd5) ? 26'd5 : fa_q;
	assign a5  = {1'b0, bwbh_q, 2'b0} + {3'b0, bwbh_q};

	logic [27:0] ct;
	logic [26:0] at;
	logic [24:0] sq_t;
	assign ct   = {crem_q, 1'b0};
	assign at   = {arem_q, 1'b0};
	assign sq_t = root_q + {1'b0, bit_q};

	// Score assembly
	logic [12:0] center, area;
	logic [22:0] area_p;
	logic [13:0] score;
	assign center = czero_q ? 13'd0 : SC_ONE - root_q[12:0];
	assign area   = afull_q ? SC_ONE : {1'b0, aq_q};
	assign area_p = area * SC_WA;
	assign score  = {1'b0, conf_q} + {3'b0, center[12:2]}
		+ {3'b0, area_p[22:FRAC_BITS]} + {4'b0, prio_weight(prio_q)}
		+ (match_q ? {3'b0, SC_WB} : 14'd0);

	// Lock update at the end of a frame
	logic        lock_d;
	logic [15:0] active_d;
	logic [7:0]  lost_d;
	always_comb begin
		lock_d   = lock_q;
		active_d = active_q;
		lost_d   = lost_q;
		if (best_found_q) begin
			lock_d   = 1'b1;
			active_d = best_track_q;
			lost_d   = 8'd0;
		end else if (lock_q) begin
			if ({1'b0, lost_q} + 9'd1 > {1'b0, cfg.max_lost}) begin
				lock_d   = 1'b0;
				active_d = 16'd0;
				lost_d   = 8'd0;
			end else begin
				lost_d = lost_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			best_found_q <= 1'b0;
			best_score_q <= '0;
			best_pos_q   <= '0;
			best_track_q <= '0;
			active_q     <= '0;
			lock_q       <= 1'b0;
			lost_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			if (cmd.capture) begin
				last_q <= last_in_frame;
				if (count_q < CNT_W'(MAX_DETECTIONS))
					count_q <= count_q + CNT_W'(1);
			end
			if (cmd.best && (!best_found_q || score_q > best_score_q)) begin
				best_found_q <= 1'b1;
				best_score_q <= score_q;
				best_pos_q   <= pos_q;
				best_track_q <= track_q;
			end
			if (cmd.frame) begin
				lock_q       <= lock_d;
				active_q     <= active_d;
				lost_q       <= lost_d;
				count_q      <= '0;
				best_found_q <= 1'b0;
				best_score_q <= '0;
				best_pos_q   <= '0;
				best_track_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			left_q  <= box_left;
			top_q   <= box_top;
			bw_q    <= box_width;
			bh_q    <= box_height;
			conf_q  <= (confidence > SC_ONE) ? SC_ONE : confidence;
			track_q <= track_tag;
			prio_q  <= prio;
			match_q <= lock_q && (track_tag == active_q);
			pos_q   <= count_q[POS_W-1:0];
		end
		if (cmd.mul) begin
			case (cmd.step)
				5'd0:    dx2_q  <= mul_p;
				5'd1:    dy2_q  <= mul_p;
				5'd2:    fw2_q  <= mul_p[25:0];
				5'd3:    fh2_q  <= mul_p[25:0];
				5'd4:    bwbh_q <= mul_p[25:0];
				default: fa_q   <= mul_p[25:0];
			endcase
		end
		if (cmd.prep) begin
			m2_q    <= m2;
			czero_q <= d2 >= {2'b0, m2};
			crem_q  <= d2[26:0];
			fad_q   <= fad;
			afull_q <= a5 >= {3'b0, fad};
			arem_q  <= a5[25:0];
			cq_q    <= '0;
			aq_q    <= '0;
			root_q  <= '0;
			bit_q   <= 24'h40_0000;
		end
		if (cmd.div) begin
			if (ct >= {1'b0, m2_q}) begin
				crem_q <= 27'(ct - {1'b0, m2_q});
				cq_q   <= {cq_q[22:0], 1'b1};
			end else begin
				crem_q <= ct[26:0];
				cq_q   <= {cq_q[22:0], 1'b0};
			end
			if (cmd.step < AREA_BITS) begin
				if (at >= {1'b0, fad_q}) begin
					arem_q <= 26'(at - {1'b0, fad_q});
					aq_q   <= {aq_q[10:0], 1'b1};
				end else begin
					arem_q <= at[25:0];
					aq_q   <= {aq_q[10:0], 1'b0};
				end
			end
		end
		// Square root of the quotient, digit by digit; the quotient register
		// holds the running remainder.
		if (cmd.sqrt) begin
			if ({1'b0, cq_q} >= sq_t) begin
				cq_q   <= 24'({1'b0, cq_q} - sq_t);
				root_q <= {1'b0, root_q[24:1]} + {1'b0, bit_q};
			end else begin
				root_q <= {1'b0, root_q[24:1]};
			end
			bit_q <= {2'b0, bit_q[23:2]};
		end
		if (cmd.sum)
			score_q <= score;
		if (cmd.frame) begin
			target_found <= best_found_q;
			target_index <= 6'(best_pos_q);
			target_score <= best_score_q;
			lock_active  <= lock_d;
			locked_track <= active_d;
			lost_count   <= lost_d;
		end
	end

endmodule

FILE: sv/primary_target_lock_selector.sv
// A scored item holds the input through the capture, multiply, setup, divide,
// square root and score steps, in that order; the divider and square root are bit-serial.
// An unscored item is taken at capture alone. A frame's last item then passes
// through a frame step that loads the result, and waits there while the previous result is stalled.
// A new item is not taken until the previous one is done.
// Reset (arst_n, asynchronous, active low) clears the lock, the frame state
// and the output valid, and loads the register defaults.
module primary_target_lock_selector import tls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        detection_valid,
	input  logic [7:0]  object_class,
	input  logic [12:0] confidence,
	input  logic [11:0] box_left,
	input  logic [11:0] box_top,
	input  logic [12:0] box_width,
	input  logic [12:0] box_height,
	input  logic [15:0] track_tag,
	input  logic        last_in_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        target_found,
	output logic [5:0]  target_index,
	output logic [13:0] target_score,
	output logic        lock_active,
	output logic [15:0] locked_track,
	output logic [7:0]  lost_count
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= 13'd640;
			cfg_q.frame_height <= 13'd480;
			cfg_q.class_first  <= 8'd0;
			cfg_q.class_second <= 8'd32;
			cfg_q.class_third  <= 8'd67;
			cfg_q.max_lost     <= 8'd8;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				REG_CLASS_FIRST:  cfg_q.class_first  <= cfg_data[7:0];
				REG_CLASS_SECOND: cfg_q.class_second <= cfg_data[7:0];
				REG_CLASS_THIRD:  cfg_q.class_third  <= cfg_data[7:0];
				REG_MAX_LOST:     cfg_q.max_lost     <= cfg_data[7:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	tls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tls_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.cmd             (cmd),
		.sts             (sts),
		.detection_valid (detection_valid),
		.object_class    (object_class),
		.confidence      (confidence),
		.box_left        (box_left),
		.box_top         (box_top),
		.box_width       (box_width),
		.box_height      (box_height),
		.track_tag       (track_tag),
		.last_in_frame   (last_in_frame),
		.target_found    (target_found),
		.target_index    (target_index),
		.target_score    (target_score),
		.lock_active     (lock_active),
		.locked_track    (locked_track),
		.lost_count      (lost_count)
	);

endmodule
